// File: rtl/core/tvdkl_pkg.sv
// Shared constants, types and helper functions for the Koren flux limiter.
package tvdkl_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 20;
  localparam int PROD_W    = 2 * DATA_W;
  // Scaled product width with the smallest shift (one below FRAC_BITS).
  localparam int TW        = PROD_W - (FRAC_BITS - 1);
  localparam int NW        = TW + 1;
  localparam int RW        = NW + 2;
  localparam int QW        = FRAC_BITS + 3;
  localparam int LW        = FRAC_BITS + 2;
  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int MUL2_W    = DIFF_W + LW + 1;
  // Reciprocal of three for operands of up to QW bits.
  localparam int DIV3_SH   = QW + 2;
  localparam int DIV3_KW   = QW + 2;
  localparam logic [DIV3_KW-1:0] DIV3_K = DIV3_KW'((64'd1 << DIV3_SH) / 3 + 1);
  localparam int DIV3_PW   = QW + DIV3_KW;
  localparam logic [QW-1:0] Q_SAT = QW'(64'd4 << FRAC_BITS);
  localparam logic [QW-1:0] Q_TWO = QW'(64'd2 << FRAC_BITS);

  localparam logic [1:0] NEAR_NONE  = 2'd0;
  localparam logic [1:0] NEAR_RIGHT = 2'd1;
  localparam logic [1:0] NEAR_HERE  = 2'd2;
  localparam logic [1:0] NEAR_LEFT  = 2'd3;

  typedef struct packed {
    logic                     go;
    logic                     dh;
    logic signed [DATA_W-1:0] low;
    logic signed [DIFF_W-1:0] diff;
  } side_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    lo = -hi - PROD_W'(1);
    if (x > hi) return hi[DATA_W-1:0];
    if (x < lo) return lo[DATA_W-1:0];
    return x[DATA_W-1:0];
  endfunction

  function automatic logic [NW-1:0] mag_n(input logic signed [NW-1:0] x);
    return x[NW-1] ? NW'(-x) : NW'(x);
  endfunction

endpackage

// File: rtl/core/tvdkl_div.sv
// Pipelined restoring divider for the smoothness ratio, one quotient bit per stage.
module tvdkl_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [tvdkl_pkg::NW-1:0]  num,
  input  logic [tvdkl_pkg::NW-1:0]  den,
  input  tvdkl_pkg::side_t          in_side,
  output logic                      out_vld,
  output logic [tvdkl_pkg::QW-1:0]  quo,
  output tvdkl_pkg::side_t          out_side
);
  import tvdkl_pkg::*;

  logic [RW-1:0]        rem  [0:DIV_STEPS];
  logic [NW-1:0]        dv   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qb   [0:DIV_STEPS];
  logic                 sat  [0:DIV_STEPS];
  logic                 vld  [0:DIV_STEPS];
  side_t                side [0:DIV_STEPS];

  assign rem[0]  = RW'(num);
  assign dv[0]   = den;
  assign qb[0]   = '0;
  assign sat[0]  = 1'b0;
  assign vld[0]  = in_vld;
  assign side[0] = in_side;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [RW-1:0] cur;
    logic [RW-1:0] dsh;
    logic          ge;
    logic          sat_new;

    always_comb begin
      // The first step tests the twos bit of the integer part, the second the ones bit.
      cur     = (j < 2) ? rem[j] : (rem[j] << 1);
      dsh     = (j == 0) ? (RW'(dv[j]) << 1) : RW'(dv[j]);
      ge      = cur >= dsh;
      sat_new = (j == 0) ? (rem[j] >= (RW'(dv[j]) << 2)) : sat[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? (cur - dsh) : cur;
        dv[j+1]   <= dv[j];
        qb[j+1]   <= {qb[j][DIV_STEPS-2:0], ge};
        sat[j+1]  <= sat_new;
        side[j+1] <= side[j];
      end
    end
  end

  assign out_vld  = vld[DIV_STEPS];
  assign quo      = sat[DIV_STEPS] ? Q_SAT : QW'(qb[DIV_STEPS]);
  assign out_side = side[DIV_STEPS];

endmodule

// File: rtl/core/tvd_flux_koren_limiter_unit.sv
// Top level of the TVD upwind flux unit with Koren limiter.
//
// Input channel (in_valid/in_ready) takes one interface stencil per word:
// four velocities, four densities and the position flags. Output channel
// (out_valid/out_ready) gives left_flux and flux_right for that word, in
// order. The unit is one stalling pipeline: a product stage, a flux and
// ratio stage, a magnitude stage, 22 divider stages for the ratio (one
// quotient bit each), then a stage for 2r and the reciprocal product,
// then limiter, blend product and output stages. One word enters and
// one leaves per cycle while the receiver is not stalling the output.
// When the receiver stalls with a result waiting, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated. Words already
// in flight behind an empty output stage keep moving. Reset clears all
// valid bits and sets den_epsilon to 1. The user must write den_epsilon through
// den_epsilon_we/den_epsilon_wdata only while the unit is idle; the block does not enforce it.
module tvd_flux_koren_limiter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              den_epsilon_we,
  input  logic [15:0]                       den_epsilon_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] vel_m2,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] vel_m1,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] vel_0,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] vel_p1,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] den_m2,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] den_m1,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] den_0,
  input  logic signed [tvdkl_pkg::DATA_W-1:0] den_p1,
  input  logic                              doubling_here,
  input  logic [1:0]                        doubling_near,
  input  logic                              limiter_on,
  input  logic                              zero_flux,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tvdkl_pkg::DATA_W-1:0] left_flux,
  output logic signed [tvdkl_pkg::DATA_W-1:0] flux_right
);
  import tvdkl_pkg::*;

  logic        adv;
  logic [15:0] eps;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= 16'd1;
    end else if (den_epsilon_we) begin
      eps <= den_epsilon_wdata;
    end
  end

  // Stage 1: the four stencil products and the upwind sign tests.
  logic                     s1_vld;
  logic signed [PROD_W-1:0] s1_p [0:3];
  logic                     s1_dh, s1_lon, s1_zf, s1_ca, s1_cb, s1_v1pos, s1_v2neg;
  logic [1:0]               s1_near;

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p[0]  <= vel_m2 * den_m2;
      s1_p[1]  <= vel_m1 * den_m1;
      s1_p[2]  <= vel_0 * den_0;
      s1_p[3]  <= vel_p1 * den_p1;
      s1_dh    <= doubling_here;
      s1_near  <= doubling_near;
      s1_lon   <= limiter_on;
      s1_zf    <= zero_flux;
      s1_ca    <= !vel_m2[DATA_W-1] && !vel_m1[DATA_W-1] && !vel_0[DATA_W-1];
      s1_cb    <= (vel_m1 <= 0) && (vel_0 <= 0) && (vel_p1 <= 0);
      s1_v1pos <= vel_m1 > 0;
      s1_v2neg <= vel_0[DATA_W-1];
    end
  end

  // Stage 2: low and high flux, ratio numerator and denominator.
  logic signed [TW-1:0]     t0, t1, t2, t3;
  logic signed [PROD_W-1:0] f1, f2, low_sum, high_sum;
  logic signed [NW-1:0]     num_c, den_c;

  always_comb begin
    t0 = (s1_near == NEAR_HERE || s1_near == NEAR_LEFT) ?
         TW'(s1_p[0] >>> (FRAC_BITS - 1)) : TW'(s1_p[0] >>> FRAC_BITS);
    t1 = (s1_near == NEAR_HERE) ?
         TW'(s1_p[1] >>> (FRAC_BITS - 1)) : TW'(s1_p[1] >>> FRAC_BITS);
    t2 = TW'(s1_p[2] >>> FRAC_BITS);
    t3 = (s1_near == NEAR_RIGHT) ?
         TW'(s1_p[3] >>> (FRAC_BITS + 1)) : TW'(s1_p[3] >>> FRAC_BITS);
    num_c = s1_ca ? (NW'(t1) - NW'(t0)) : (NW'(t3) - NW'(t2));
    den_c = NW'(t2) - NW'(t1);
    // The right-hand term is halved at a doubling interface.
    f1 = s1_p[1] >>> FRAC_BITS;
    f2 = s1_dh ? (s1_p[2] >>> (FRAC_BITS + 1)) : (s1_p[2] >>> FRAC_BITS);
    low_sum  = (s1_v1pos ? f1 : '0) + (s1_v2neg ? f2 : '0);
    high_sum = (f1 + f2) >>> 1;
  end

  logic                     s2_vld, s2_go, s2_dh;
  logic signed [DATA_W-1:0] s2_low, s2_high;
  logic signed [NW-1:0]     s2_num, s2_den;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_low  <= s1_zf ? '0 : sat_data(low_sum);
      s2_high <= s1_zf ? '0 : sat_data(high_sum);
      s2_num  <= num_c;
      s2_den  <= den_c;
      s2_go   <= s1_lon && (s1_ca || s1_cb);
      s2_dh   <= s1_dh;
    end
  end

  // Stage 3: magnitudes and the tests that force the limiter to zero.
  logic          s3_vld;
  logic [NW-1:0] s3_n, s3_d;
  side_t         s3_side;
  logic [NW-1:0] dmag;

  assign dmag = mag_n(s2_den);

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_n         <= mag_n(s2_num);
      s3_d         <= dmag;
      s3_side.go   <= s2_go && (s2_num != '0) && (s2_den != '0) &&
                      (s2_num[NW-1] == s2_den[NW-1]) && (dmag >= NW'(eps));
      s3_side.dh   <= s2_dh;
      s3_side.low  <= s2_low;
      s3_side.diff <= DIFF_W'(s2_high) - DIFF_W'(s2_low);
    end
  end

  logic          dv_vld;
  logic [QW-1:0] dv_q;
  side_t         dv_side;

  tvdkl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s3_vld),
    .num      (s3_n),
    .den      (s3_d),
    .in_side  (s3_side),
    .out_vld  (dv_vld),
    .quo      (dv_q),
    .out_side (dv_side)
  );

  // Stage 4: 2r and the reciprocal product for (2 + r) / 3.
  logic               s4_vld;
  logic [QW:0]        s4_a;
  logic [DIV3_PW-1:0] s4_b3;
  side_t              s4_side;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_a    <= {dv_q, 1'b0};
      s4_b3   <= DIV3_PW'(Q_TWO + dv_q) * DIV3_PW'(DIV3_K);
      s4_side <= dv_side;
    end
  end

  // Stage 5: limiter value.
  logic          s5_vld;
  logic [LW-1:0] s5_lim;
  side_t         s5_side;
  logic [QW:0]   b_c, m_c;

  always_comb begin
    b_c = (QW + 1)'(s4_b3 >> DIV3_SH);
    m_c = (s4_a < b_c) ? s4_a : b_c;
    if ((QW + 1)'(Q_TWO) < m_c) m_c = (QW + 1)'(Q_TWO);
  end

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else if (adv) s5_vld <= s4_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_lim  <= s4_side.go ? LW'(m_c) : '0;
      s5_side <= s4_side;
    end
  end

  // Stage 6: blend product L * (high - low).
  logic                     s6_vld;
  logic signed [MUL2_W-1:0] s6_prod;
  side_t                    s6_side;

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else if (adv) s6_vld <= s5_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_prod <= MUL2_W'(s5_side.diff) * MUL2_W'($signed({1'b0, s5_lim}));
      s6_side <= s5_side;
    end
  end

  // Stage 7: output register.
  logic signed [PROD_W-1:0] sum_c;

  assign sum_c = PROD_W'(s6_side.low) + PROD_W'(s6_prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s6_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_flux  <= sat_data(sum_c);
      flux_right <= s6_side.dh ? sat_data(sum_c <<< 1) : sat_data(sum_c);
    end
  end

endmodule

// File: rtl/core/tvdkl_checker.sv
// Port-level assertions for the flux limiter unit, bound to its top level.
module tvdkl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tvdkl_pkg::DATA_W-1:0] left_flux,
  input logic signed [tvdkl_pkg::DATA_W-1:0] flux_right
);
  import tvdkl_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_flux) && $stable(flux_right))
    else $error("stalled result word changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && left_flux == 0 |-> flux_right == 0)
    else $error("right flux nonzero with zero left flux");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && flux_right != left_flux |-> flux_right[DATA_W-1] == left_flux[DATA_W-1])
    else $error("right flux sign differs from left flux");

endmodule

bind tvd_flux_koren_limiter_unit tvdkl_checker u_tvdkl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .left_flux  (left_flux),
  .flux_right (flux_right)
);

// File: test/tvdkl_checker.sv
// Checker for the Koren flux limiter: predicts each flux pair and compares results in order.
`timescale 1ns / 1ps

module tvdkl_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        den_epsilon_we,
  input  logic [15:0] den_epsilon_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] vel_m2,
  input  logic [31:0] vel_m1,
  input  logic [31:0] vel_0,
  input  logic [31:0] vel_p1,
  input  logic [31:0] den_m2,
  input  logic [31:0] den_m1,
  input  logic [31:0] den_0,
  input  logic [31:0] den_p1,
  input  logic        doubling_here,
  input  logic [1:0]  doubling_near,
  input  logic        limiter_on,
  input  logic        zero_flux,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] left_flux,
  input  logic [31:0] flux_right,
  output int          fail_count,
  output int          pending
);
  import tvdkl_pkg::*;

  localparam int FB = FRAC_BITS;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
  } flux_pair_t;

  flux_pair_t  flux_q[$];
  logic [15:0] eps_reg;
  int          checked;

  assign pending = flux_q.size();

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint abs64(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Koren limiter value in Q.20 from the ratio numerator and denominator.
  function automatic longint koren_phi(input longint num, input longint den);
    longint unsigned n, d, ip, rem, q, two, a, b, lim;
    if (num == 0 || den == 0) return 0;
    if ((num > 0) != (den > 0)) return 0;
    n = abs64(num);
    d = abs64(den);
    ip = n / d;
    if (ip >= 4) begin
      q = 64'd4 << FB;
    end else begin
      rem = n % d;
      q = ip;
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q = q | 64'd1;
        end
      end
    end
    two = 64'd2 << FB;
    a = 2 * q;
    b = (two + q) / 3;
    lim = (a < b) ? a : b;
    if (two < lim) lim = two;
    return longint'(lim);
  endfunction

  function automatic flux_pair_t predict_flux(input logic [31:0] vw[4], input logic [31:0] pw[4],
                                              input logic dh, input logic [1:0] near,
                                              input logic lon, input logic zf,
                                              input logic [15:0] eps);
    longint v[4], p[4], t[4];
    int sh[4];
    longint lo, hi, lim, num, den, flux, rgt;
    int hs;
    bit ok;
    flux_pair_t res;
    lo = 0;
    hi = 0;
    lim = 0;
    num = 0;
    den = 0;
    ok = 0;
    for (int k = 0; k < 4; k++) begin
      v[k] = longint'(signed'(vw[k]));
      p[k] = longint'(signed'(pw[k]));
    end
    if (!zf) begin
      hs = dh ? FB + 1 : FB;
      lo = (((v[1] > 0) ? v[1] : 0) * p[1] >>> FB) + (((v[2] < 0) ? v[2] : 0) * p[2] >>> hs);
      hi = ((v[1] * p[1] >>> FB) + (v[2] * p[2] >>> hs)) >>> 1;
      lo = clamp32(lo);
      hi = clamp32(hi);
    end
    if (lon) begin
      for (int k = 0; k < 4; k++) sh[k] = FB;
      case (near)
        NEAR_RIGHT: sh[3] = FB + 1;
        NEAR_HERE: begin
          sh[0] = FB - 1;
          sh[1] = FB - 1;
        end
        NEAR_LEFT: sh[0] = FB - 1;
        default: ;
      endcase
      for (int k = 0; k < 4; k++) t[k] = (v[k] * p[k]) >>> sh[k];
      if (v[0] >= 0 && v[1] >= 0 && v[2] >= 0) begin
        num = t[1] - t[0];
        den = t[2] - t[1];
        ok = 1;
      end else if (v[1] <= 0 && v[2] <= 0 && v[3] <= 0) begin
        num = t[3] - t[2];
        den = t[2] - t[1];
        ok = 1;
      end
      if (ok && abs64(den) >= longint'(eps)) lim = koren_phi(num, den);
    end
    flux = clamp32(lo + ((lim * (hi - lo)) >>> FB));
    rgt = dh ? clamp32(2 * flux) : flux;
    res.left = flux[31:0];
    res.right = rgt[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [31:0] vw[4];
    logic [31:0] pw[4];
    flux_pair_t  want;
    if (rst) begin
      eps_reg <= 16'd1;
      flux_q.delete();
      checked = 0;
    end else begin
      if (den_epsilon_we) eps_reg <= den_epsilon_wdata;
      if (in_valid && in_ready) begin
        vw = '{vel_m2, vel_m1, vel_0, vel_p1};
        pw = '{den_m2, den_m1, den_0, den_p1};
        flux_q.push_back(predict_flux(vw, pw, doubling_here, doubling_near,
                                      limiter_on, zero_flux, eps_reg));
      end
      if (out_valid && out_ready) begin
        if (flux_q.size() == 0) begin
          fail_count++;
          $display("MISMATCH unexpected result word %h %h", left_flux, flux_right);
        end else begin
          want = flux_q.pop_front();
          if (left_flux !== want.left) report_mismatch("left_flux", left_flux, want.left);
          if (flux_right !== want.right) report_mismatch("flux_right", flux_right, want.right);
        end
        checked++;
      end
    end
  end

endmodule

// File: test/testbench.sv
// Testbench top for the Koren flux limiter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
  import tvdkl_pkg::*;

  localparam int LATENCY = 29;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        den_epsilon_we = 1'b0;
  logic [15:0] den_epsilon_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] vel_m2 = '0, vel_m1 = '0, vel_0 = '0, vel_p1 = '0;
  logic [31:0] den_m2 = '0, den_m1 = '0, den_0 = '0, den_p1 = '0;
  logic        doubling_here = 1'b0;
  logic [1:0]  doubling_near = NEAR_NONE;
  logic        limiter_on = 1'b0;
  logic        zero_flux = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] left_flux, flux_right;
  int          fail_count, pending;
  bit          calm = 0;
  int          words_sent = 0;
  int          settings_used = 0;

  always #5 clk = ~clk;

  tvd_flux_koren_limiter_unit u_dut (
    .clk(clk), .rst(rst),
    .den_epsilon_we(den_epsilon_we), .den_epsilon_wdata(den_epsilon_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .vel_m2(vel_m2), .vel_m1(vel_m1), .vel_0(vel_0), .vel_p1(vel_p1),
    .den_m2(den_m2), .den_m1(den_m1), .den_0(den_0), .den_p1(den_p1),
    .doubling_here(doubling_here), .doubling_near(doubling_near),
    .limiter_on(limiter_on), .zero_flux(zero_flux),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_flux(left_flux), .flux_right(flux_right)
  );

  tvdkl_scoreboard u_chk (
    .clk(clk), .rst(rst),
    .den_epsilon_we(den_epsilon_we), .den_epsilon_wdata(den_epsilon_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .vel_m2(vel_m2), .vel_m1(vel_m1), .vel_0(vel_0), .vel_p1(vel_p1),
    .den_m2(den_m2), .den_m1(den_m1), .den_0(den_0), .den_p1(den_p1),
    .doubling_here(doubling_here), .doubling_near(doubling_near),
    .limiter_on(limiter_on), .zero_flux(zero_flux),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_flux(left_flux), .flux_right(flux_right),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stall bursts, none once the run turns calm.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        gap = $urandom_range(1, 16);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Present one word and hold it until accepted; may leave a gap afterwards.
  task automatic send_word(input logic [31:0] v[4], input logic [31:0] p[4],
                           input logic dh, input logic [1:0] near,
                           input logic lon, input logic zf);
    vel_m2 <= v[0]; vel_m1 <= v[1]; vel_0 <= v[2]; vel_p1 <= v[3];
    den_m2 <= p[0]; den_m1 <= p[1]; den_0 <= p[2]; den_p1 <= p[3];
    doubling_here <= dh; doubling_near <= near;
    limiter_on <= lon; zero_flux <= zf;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic drain_then_write(input logic [15:0] eps);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 6) @(negedge clk);
    den_epsilon_we <= 1'b1;
    den_epsilon_wdata <= eps;
    @(negedge clk);
    den_epsilon_we <= 1'b0;
    settings_used++;
  endtask

  // Random word; most are smooth stencils with one upwind sign so the ratio path is exercised.
  task automatic random_word();
    logic [31:0] v[4], p[4];
    int mode, base, slope, sgn, vm;
    mode = $urandom_range(0, 9);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    base = $urandom_range(0, 1 << 24) - (1 << 23);
    slope = $urandom_range(0, 1 << 20) - (1 << 19);
    for (int k = 0; k < 4; k++) begin
      case (mode)
        0, 1: begin
          v[k] = $urandom();
          p[k] = $urandom();
        end
        2, 3: begin
          // Unit-magnitude velocity so products equal densities up to sign; tiny steps test the epsilon threshold.
          v[k] = sgn * (1 << FRAC_BITS);
          p[k] = base + k * $urandom_range(0, 70000);
        end
        4: begin
          v[k] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
          p[k] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        end
        default: begin
          vm = $urandom_range(0, 1 << 22);
          v[k] = ($urandom_range(0, 15) == 0) ? -sgn * vm : sgn * vm;
          p[k] = base + k * slope + $urandom_range(0, 4095);
        end
      endcase
    end
    send_word(v, p, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
              $urandom_range(0, 7) != 0, $urandom_range(0, 11) == 0);
  endtask

  initial begin
    logic [31:0] v[4], p[4];
    logic [15:0] eps_list[6];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the default epsilon.
    v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    p = v;
    send_word(v, p, 1'b1, NEAR_NONE, 1'b1, 1'b0);
    v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
    send_word(v, p, 1'b1, NEAR_HERE, 1'b1, 1'b0);
    p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    send_word(v, p, 1'b0, NEAR_LEFT, 1'b1, 1'b0);
    v = '{0, 0, 0, 0};
    send_word(v, p, 1'b0, NEAR_NONE, 1'b1, 1'b0);
    // Smooth positive stencil under each neighbour doubling code.
    v = '{32'h00100000, 32'h00100000, 32'h00100000, 32'h00100000};
    p = '{32'h00100000, 32'h00200000, 32'h00300000, 32'h00400000};
    for (int n = 0; n < 4; n++) begin
      send_word(v, p, 1'b0, n[1:0], 1'b1, 1'b0);
      send_word(v, p, 1'b1, n[1:0], 1'b1, 1'b0);
    end
    // Negative velocities take the downstream side of the stencil.
    v = '{32'hfff00000, 32'hfff00000, 32'hfff00000, 32'hfff00000};
    send_word(v, p, 1'b0, NEAR_RIGHT, 1'b1, 1'b0);
    // Mixed signs give no upwind side; a flat stencil gives a zero denominator.
    v = '{32'h00100000, 32'hfff00000, 32'h00100000, 32'h00100000};
    send_word(v, p, 1'b0, NEAR_NONE, 1'b1, 1'b0);
    v = '{32'h00100000, 32'h00100000, 32'h00100000, 32'h00100000};
    p = '{32'h00100000, 32'h00100000, 32'h00100000, 32'h00200000};
    send_word(v, p, 1'b0, NEAR_NONE, 1'b1, 1'b0);
    // Denominator equal to epsilon, ratio negative, ratio large.
    p = '{32'h00100000, 32'h00200000, 32'h00200001, 32'h0};
    send_word(v, p, 1'b0, NEAR_NONE, 1'b1, 1'b0);
    p = '{32'h00300000, 32'h00200000, 32'h00300000, 32'h0};
    send_word(v, p, 1'b0, NEAR_NONE, 1'b1, 1'b0);
    p = '{32'h00000000, 32'h00900000, 32'h00a00000, 32'h0};
    send_word(v, p, 1'b0, NEAR_NONE, 1'b1, 1'b0);
    // Boundary and Dirichlet interfaces.
    send_word(v, p, 1'b1, NEAR_HERE, 1'b0, 1'b0);
    send_word(v, p, 1'b1, NEAR_HERE, 1'b1, 1'b1);

    // Random phases over several epsilon settings; the first write also drains the pipe.
    eps_list = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(2, 65534)), 16'd300, 16'd0};
    for (int ph = 0; ph < 6; ph++) begin
      drain_then_write(eps_list[ph]);
      if (ph == 5) calm = 1;
      repeat (215) random_word();
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Ran %0d words through %0d epsilon settings plus the reset default.",
             words_sent, settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("** tvd_flux_koren_limiter_unit: PASSED **");
    end else begin
      $display("Failures: %0d, results still owed: %0d", fail_count, pending);
      $display("** tvd_flux_koren_limiter_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timeout with %0d results still owed.", pending);
    $display("** tvd_flux_koren_limiter_unit: FAILED **");
    $finish;
  end

endmodule
